/* design/slice_area_piece_measurer_macros.svh */
// Assertion macros used by the measurer module.
`ifndef SLICE_AREA_PIECE_MEASURER_MACROS_SVH
`define SLICE_AREA_PIECE_MEASURER_MACROS_SVH
// Checks that an implication holds at every rising clock edge outside reset.
`define SAPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks a next-cycle implication outside reset.
`define SAPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/sapm_pkg.sv */
//------------------------------------------------------------------------------
// sapm_pkg
// Types and constants for the slice area piece measurer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sapm_pkg;
  localparam int SENSOR_COUNT_DEF    = 11;
  localparam int BITS_PER_SENSOR_DEF = 10;
  localparam int END_STEPS_DEF       = 3;

  localparam logic [1:0] CFG_UNIT_MODE = 2'd0;
  localparam logic [1:0] CFG_SCALE_SEL = 2'd1;
  localparam logic [1:0] CFG_PIECES    = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PIECE = 2'd1;
  localparam logic [1:0] EV_FULL  = 2'd2;

  localparam logic [24:0] SLICE_PER_BIT_Q32 = 25'd19468607;
  localparam logic [31:0] NOISE_PRE_Q16     = 32'd6554;
  localparam logic [31:0] NOISE_POST_Q16    = 32'd32768;
  localparam logic [15:0] ROUND_UP_LIMIT    = 16'd9831;
  localparam logic [28:0] M2_RECIP_Q32      = 29'd386547095;
  localparam logic signed [48:0] ACC_LIMIT  = 49'sd140737488355327;

  typedef struct packed {
    logic [9:0] sensor_word_0;
    logic [9:0] sensor_word_1;
    logic [9:0] sensor_word_2;
    logic [9:0] sensor_word_3;
    logic [9:0] sensor_word_4;
    logic [9:0] sensor_word_5;
    logic [9:0] sensor_word_6;
    logic [9:0] sensor_word_7;
    logic [9:0] sensor_word_8;
    logic [9:0] sensor_word_9;
    logic [9:0] sensor_word_10;
    logic       speed_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_code;
    logic signed [31:0] piece_area;
    logic [15:0]        piece_total;
    logic signed [31:0] batch_area;
    logic               measuring;
  } out_item_t;

  // Control to the finishing unit.
  typedef struct packed {
    logic        start;
    logic        high;
    logic        unit_mode;
    logic [1:0]  scale_select;
    logic [31:0] accum;
  } fin_req_t;

  typedef struct packed {
    logic               done;
    logic               keep;
    logic signed [31:0] area;
  } fin_rsp_t;

  function automatic logic signed [48:0] poly_coef(input logic high, input logic [1:0] i);
    logic signed [48:0] r;
    r = '0;
    case (i)
      2'd0: r = high ? 49'sd20630119   : 49'sd7242818;
      2'd1: r = high ? -49'sd353570109 : -49'sd170916935;
      2'd2: r = high ? 49'sd7273183304 : 49'sd5282423227;
      2'd3: r = high ? -49'sd908398039 : -49'sd1029486481;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] ft2_factor(input logic [1:0] s);
    logic [16:0] r;
    case (s)
      2'd0:    r = 17'd75232;
      2'd1:    r = 17'd65536;
      default: r = 17'd63488;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* design/slice_area_piece_measurer.sv */
//------------------------------------------------------------------------------
// slice_area_piece_measurer
// Per-step slice area measurement, piece closure and batch accounting.
//------------------------------------------------------------------------------
// One beat per encoder step. An input beat passes through the bit column
// counter (one column of sensor bits per cycle) and the bookkeeping states;
// a step that closes a piece also passes through the finishing unit, with
// its three 8-digit serial multiplies of the cubic and one for the unit
// conversion. The result beat sits in an output register and the next input
// beat is taken once that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "slice_area_piece_measurer_macros.svh"
module slice_area_piece_measurer #(
  parameter int SENSOR_COUNT    = sapm_pkg::SENSOR_COUNT_DEF,
  parameter int BITS_PER_SENSOR = sapm_pkg::BITS_PER_SENSOR_DEF,
  parameter int END_STEPS       = sapm_pkg::END_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sapm_pkg::in_item_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output sapm_pkg::out_item_t out_payload,
  input  wire logic cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sapm_pkg::*;
  localparam int CW = $clog2(SENSOR_COUNT * BITS_PER_SENSOR + 1);
  localparam int NB = SENSOR_COUNT * BITS_PER_SENSOR;

  typedef enum logic [1:0] {S_IDLE, S_COUNT, S_FIN, S_OUT} st_t;
  st_t st_r;
  logic unit_mode_r;
  logic [1:0] scale_r;
  logic [15:0] ppb_r;
  logic in_piece_r;
  logic [1:0] empty_r;
  logic [31:0] paccum_r;
  logic [15:0] pcount_r;
  logic signed [31:0] baccum_r;
  logic high_r;
  logic cnt_start, cnt_done;
  logic [CW-1:0] cnt;
  logic [NB-1:0] words;
  logic [10:0][9:0] sw;
  fin_req_t freq;
  fin_rsp_t frsp;

  // Only the low BITS_PER_SENSOR bits of each sensor word are counted.
  assign sw = {in_data.sensor_word_10, in_data.sensor_word_9, in_data.sensor_word_8,
               in_data.sensor_word_7, in_data.sensor_word_6, in_data.sensor_word_5,
               in_data.sensor_word_4, in_data.sensor_word_3, in_data.sensor_word_2,
               in_data.sensor_word_1, in_data.sensor_word_0};
  always_comb begin
    for (int s = 0; s < SENSOR_COUNT; s++)
      words[s*BITS_PER_SENSOR +: BITS_PER_SENSOR] = BITS_PER_SENSOR'(sw[s]);
  end

  assign in_ready  = (st_r == S_IDLE) && !out_valid;
  assign cnt_start = in_valid && in_ready;

  sapm_bit_counter #(.SENSOR_COUNT(SENSOR_COUNT), .BITS_PER_SENSOR(BITS_PER_SENSOR)) u_cnt (
    .clk, .rst_n, .start(cnt_start), .words, .done(cnt_done), .count(cnt));

  sapm_finisher u_fin (.clk, .rst_n, .req(freq), .rsp(frsp));

  logic [56:0] slice;
  logic [32:0] psum;
  assign slice = (57'(cnt) * 57'(SLICE_PER_BIT_Q32) + 57'd32768) >> 16;
  assign psum  = 33'(in_piece_r ? paccum_r : 32'd0) + 33'(slice);

  logic signed [32:0] bsum;
  logic [15:0] pc_new;
  assign bsum = 33'(baccum_r) + 33'(frsp.area);
  assign pc_new = (pcount_r == 16'hFFFF) ? pcount_r : pcount_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
      unit_mode_r <= 1'b0; scale_r <= 2'd1; ppb_r <= 16'd1;
      in_piece_r <= 1'b0; empty_r <= '0; paccum_r <= '0; pcount_r <= '0; baccum_r <= '0;
      freq <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNIT_MODE: unit_mode_r <= cfg_data[0];
          CFG_SCALE_SEL: scale_r <= cfg_data[1:0];
          CFG_PIECES:    ppb_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (cnt_start) begin
          high_r <= in_data.speed_high;
          st_r <= S_COUNT;
        end
        S_COUNT: if (cnt_done) begin
          out_payload.event_code <= EV_NONE;
          out_payload.piece_area <= '0;
          out_payload.piece_total <= pcount_r;
          out_payload.batch_area <= baccum_r;
          st_r <= S_OUT;
          if (cnt != '0) begin
            in_piece_r <= 1'b1; empty_r <= '0;
            paccum_r <= psum[32] || psum[31] ? 32'h7FFFFFFF : psum[31:0];
            out_payload.measuring <= 1'b1;
          end else if (in_piece_r) begin
            if (32'(empty_r) + 1 >= END_STEPS) begin
              in_piece_r <= 1'b0; empty_r <= '0;
              out_payload.measuring <= 1'b0;
              freq <= '{start: 1'b1, high: high_r, unit_mode: unit_mode_r,
                        scale_select: scale_r, accum: paccum_r};
              paccum_r <= '0;
              st_r <= S_FIN;
            end else begin
              empty_r <= empty_r + 1'b1;
              out_payload.measuring <= 1'b1;
            end
          end else begin
            paccum_r <= '0;
            out_payload.measuring <= 1'b0;
          end
        end
        S_FIN: begin
          // The start request lasts exactly the first cycle in this state.
          freq.start <= 1'b0;
          if (frsp.done) begin
            st_r <= S_OUT;
            if (frsp.keep) begin
              logic signed [31:0] b;
              b = (bsum > 33'sd2147483647) ? 32'sh7FFFFFFF :
                  (bsum < -33'sd2147483648) ? 32'sh80000000 : bsum[31:0];
              out_payload.piece_area <= frsp.area;
              out_payload.piece_total <= pc_new;
              out_payload.batch_area <= b;
              if (pc_new >= ppb_r) begin
                out_payload.event_code <= EV_FULL;
                pcount_r <= '0; baccum_r <= '0;
              end else begin
                out_payload.event_code <= EV_PIECE;
                pcount_r <= pc_new; baccum_r <= b;
              end
            end
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `SAPM_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !out_valid)
  `SAPM_ASSERT_NEXT(a_fin_start, clk, rst_n, freq.start, st_r == S_FIN)
  `SAPM_ASSERT_IMPL(a_event_area, clk, rst_n,
                    out_valid && out_payload.event_code == EV_NONE, out_payload.piece_area == 0)
endmodule
`default_nettype wire

/* design/sapm_bit_counter.sv */
//------------------------------------------------------------------------------
// sapm_bit_counter
// Counts lit bits by shifting the sensor words out one bit column per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sapm_bit_counter #(
  parameter int SENSOR_COUNT    = 11,
  parameter int BITS_PER_SENSOR = 10,
  localparam int CW = $clog2(SENSOR_COUNT * BITS_PER_SENSOR + 1),
  localparam int BW = $clog2(BITS_PER_SENSOR + 1)
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [SENSOR_COUNT*BITS_PER_SENSOR-1:0] words,
  output logic      done,
  output logic [CW-1:0] count
);
  logic [SENSOR_COUNT*BITS_PER_SENSOR-1:0] sh_r;
  logic [BW-1:0] left_r;
  logic busy_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] col;

  // Each cycle adds the low bit of every sensor word.
  always_comb begin
    col = '0;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      col = col + CW'(sh_r[s*BITS_PER_SENSOR]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      left_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        left_r <= BW'(BITS_PER_SENSOR);
        cnt_r  <= '0;
        sh_r   <= words;
      end else if (busy_r) begin
        cnt_r <= cnt_r + col;
        sh_r  <= sh_r >> 1;
        left_r <= left_r - 1'b1;
        if (left_r == BW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign count = cnt_r;
endmodule
`default_nettype wire

/* design/sapm_finisher.sv */
//------------------------------------------------------------------------------
// sapm_finisher
// Noise checks, cubic calibration and unit conversion of one finished piece.
// The multiplications are done digit-serially, four bits of the second operand per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sapm_finisher (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sapm_pkg::fin_req_t req,
  output sapm_pkg::fin_rsp_t rsp
);
  import sapm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_ROUND, S_CONV, S_CMUL, S_QUANT} st_t;
  st_t st_r;
  logic [1:0] step_r;
  logic [3:0] dig_r;
  logic high_r, mode_r;
  logic [1:0] sel_r;
  logic [31:0] x_r;
  logic signed [48:0] acc_r;
  logic [47:0] mag_r;
  logic neg_r;
  logic [31:0] xs_r;
  logic [79:0] prod_r;
  logic signed [31:0] y_r;

  logic [79:0] pp;
  logic signed [65:0] sum;
  logic signed [48:0] sum_cl;
  logic signed [50:0] rnd;
  logic signed [34:0] ysh;

  // Partial product of magnitude with the low nibble of the shifted operand.
  assign pp = 80'(mag_r) * 80'(xs_r[3:0]);
  // The full product shifted down by 16 can reach well past the clamp limit,
  // so the whole upper part takes part in the sum before clamping.
  assign sum = (neg_r ? -$signed({2'b00, prod_r[79:16]}) : $signed({2'b00, prod_r[79:16]}))
               + 66'(poly_coef(high_r, step_r));
  assign sum_cl = (sum > 66'(ACC_LIMIT)) ? ACC_LIMIT :
                  (sum < -66'(ACC_LIMIT)) ? -ACC_LIMIT : sum[48:0];
  assign rnd = 51'(acc_r) + 51'sd32768;
  assign ysh = 35'(rnd >>> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rsp  <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (req.start) begin
            high_r <= req.high; mode_r <= req.unit_mode; sel_r <= req.scale_select;
            x_r <= req.accum;
            if (!req.unit_mode && (req.accum < NOISE_PRE_Q16)) begin
              rsp <= '{done: 1'b1, keep: 1'b0, area: '0};
            end else begin
              rsp.done <= 1'b0;
              acc_r <= poly_coef(req.high, 2'd0);
              mag_r <= 48'(poly_coef(req.high, 2'd0));
              neg_r <= 1'b0;
              xs_r <= req.accum; prod_r <= '0; dig_r <= '0;
              step_r <= 2'd1;
              st_r <= S_MUL;
            end
          end else begin
            rsp.done <= 1'b0;
          end
        end
        S_MUL: begin
          prod_r <= prod_r + (pp << {dig_r, 2'b00});
          xs_r <= xs_r >> 4;
          dig_r <= dig_r + 1'b1;
          if (dig_r == 4'd7) st_r <= S_ADD;
        end
        S_ADD: begin
          acc_r <= sum_cl;
          if (step_r == 2'd3) begin
            st_r <= S_ROUND;
          end else begin
            step_r <= step_r + 1'b1;
            neg_r <= sum_cl < 0;
            mag_r <= (sum_cl < 0) ? 48'(-sum_cl) : 48'(sum_cl);
            xs_r <= x_r; prod_r <= '0; dig_r <= '0;
            st_r <= S_MUL;
          end
        end
        S_ROUND: begin
          y_r <= (ysh > 35'sd2147483647) ? 32'sh7FFFFFFF :
                 (ysh < -35'sd2147483648) ? 32'sh80000000 : ysh[31:0];
          st_r <= S_CONV;
        end
        S_CONV: begin
          if (!mode_r && (y_r < signed'(NOISE_POST_Q16))) begin
            rsp <= '{done: 1'b1, keep: 1'b0, area: '0};
            st_r <= S_IDLE;
          end else begin
            neg_r <= y_r[31];
            mag_r <= y_r[31] ? 48'(-33'(y_r)) : 48'(y_r);
            xs_r <= mode_r ? 32'(M2_RECIP_Q32) : 32'(ft2_factor(sel_r));
            prod_r <= '0; dig_r <= '0;
            st_r <= S_CMUL;
          end
        end
        S_CMUL: begin
          prod_r <= prod_r + (pp << {dig_r, 2'b00});
          xs_r <= xs_r >> 4;
          dig_r <= dig_r + 1'b1;
          if (dig_r == 4'd7) st_r <= S_QUANT;
        end
        S_QUANT: begin
          st_r <= S_IDLE;
          rsp.done <= 1'b1;
          rsp.keep <= 1'b1;
          if (mode_r) begin
            // Signed multiply by reciprocal, rounded half up (floor of p + 2^31).
            rsp.area <= neg_r ? 32'(-$signed({1'b0, prod_r[63:0]} - 65'd2147483648) >>> 32)
                              : 32'((prod_r[63:0] + 64'd2147483648) >> 32);
          end else begin
            logic [48:0] z;
            logic [31:0] zc, base;
            z = 49'((prod_r[48:0] + 49'd32768) >> 16);
            zc = (z > 49'h7FFFFFFF) ? 32'h7FFFFFFF : z[31:0];
            base = {zc[31:14], 14'd0};
            if (zc[13:0] >= ROUND_UP_LIMIT[13:0] && base <= 32'h7FFFBFFF)
              base = base + 32'd16384;
            rsp.area <= base;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
